// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// prop holds at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// cond is never true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_HOLDS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== rtl/hidd_pkg.sv =====
package hidd_pkg;

   localparam int KEY_COUNT  = 32;
   localparam int KEY_W      = $clog2(KEY_COUNT);
   localparam int KEY_CODE_W = 6;
   localparam int AXIS_W     = 16;
   localparam int AXIS_COUNT = 6;

   localparam logic [15:0] VENDOR_RESET = 16'h046d;
   localparam logic [15:0] PROD_A       = 16'hc625;
   localparam logic [15:0] PROD_B       = 16'hc627;

   localparam logic [7:0] REPORT_PAN  = 8'h01;
   localparam logic [7:0] REPORT_ROT  = 8'h02;
   localparam logic [7:0] REPORT_KEYS = 8'h03;
   localparam logic [7:0] LONG_REPORT_MIN = 8'd13;

   localparam logic [1:0] KIND_MOTION   = 2'd0;
   localparam logic [1:0] KIND_KEY_DOWN = 2'd1;
   localparam logic [1:0] KIND_KEY_UP   = 2'd2;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam int TABLE_A_LEN = 21;
   localparam int TABLE_B_LEN = 16;

   localparam logic [4:0] TABLE_A [TABLE_A_LEN] = '{
      5'd0, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd3, 5'd4, 5'd5, 5'd6,
      5'd23, 5'd24, 5'd25, 5'd26, 5'd2, 5'd1, 5'd30, 5'd31, 5'd29, 5'd27
   };
   localparam logic [4:0] TABLE_B [TABLE_B_LEN] = '{
      5'd0, 5'd13, 5'd14, 5'd3, 5'd4, 5'd5, 5'd6, 5'd23,
      5'd24, 5'd25, 5'd26, 5'd2, 5'd1, 5'd30, 5'd31, 5'd27
   };

   typedef logic [AXIS_COUNT-1:0][AXIS_W-1:0] axes_type;

   // one queued command: a motion snapshot or a key scan
   typedef struct packed {
      logic                 is_key;
      axes_type             axes;
      logic [KEY_COUNT-1:0] keys;
      logic [KEY_COUNT-1:0] mask;
      logic [15:0]          pid;
   } cmd_type;

   function automatic logic [KEY_CODE_W-1:0] map_key(input logic [15:0] pid,
                                                     input logic [KEY_CODE_W-1:0] key);
      logic [KEY_CODE_W-1:0] code;
      code = key;
      if (pid == PROD_A) begin
         code = (key < KEY_CODE_W'(TABLE_A_LEN)) ?
                KEY_CODE_W'(TABLE_A[key[$clog2(TABLE_A_LEN)-1:0]]) : '0;
      end else if (pid == PROD_B) begin
         code = (key < KEY_CODE_W'(TABLE_B_LEN)) ?
                KEY_CODE_W'(TABLE_B[key[$clog2(TABLE_B_LEN)-1:0]]) : '0;
      end
      return code;
   endfunction

endpackage

// ===== rtl/hidd_cmd_fifo.sv =====
`include "assert_macros.svh"

module hidd_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hidd_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output hidd_pkg::cmd_type pop_data,
   output logic             empty
);
   import hidd_pkg::*;

   cmd_type                 entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_NEVER(a_no_push_full, clock, reset, push && full)
   `ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && empty)

endmodule

// ===== rtl/hidd_front.sv =====
`include "assert_macros.svh"

module hidd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_wdata,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_is_hid,
   input  logic              req_foreground,
   input  logic [15:0]       req_vendor_id,
   input  logic [15:0]       req_product_id,
   input  logic [7:0]        req_report_size,
   input  logic [7:0]        req_report_id,
   input  logic [15:0]       req_word_a,
   input  logic [15:0]       req_word_b,
   input  logic [15:0]       req_word_c,
   input  logic [15:0]       req_word_d,
   input  logic [15:0]       req_word_e,
   input  logic [15:0]       req_word_f,
   output logic              push,
   output hidd_pkg::cmd_type push_data,
   input  logic              full
);
   import hidd_pkg::*;

   logic [15:0]          vendor_ff;
   axes_type             axes_ff, axes_in;
   logic [KEY_COUNT-1:0] prev_keys_ff, prev_keys_in;
   logic                 accept;
   logic                 match;
   logic [KEY_COUNT-1:0] keys;
   logic [KEY_COUNT-1:0] change;
   logic [KEY_COUNT-1:0] emit_mask;

   assign csr_ready = 1'b1;
   assign req_ready = !full;
   assign accept    = req_valid && req_ready;
   assign match     = req_is_hid && (req_vendor_id == vendor_ff);
   assign keys      = KEY_COUNT'({req_word_b, req_word_a});
   assign change    = keys ^ prev_keys_ff;

   // keys whose code maps to zero never show up downstream
   always_comb begin
      for (int i = 0; i < KEY_COUNT; i++) begin
         emit_mask[i] = change[i] &&
                        (map_key(req_product_id, KEY_CODE_W'(i + 1)) != '0);
      end
   end

   always_comb begin
      axes_in      = axes_ff;
      prev_keys_in = prev_keys_ff;
      push         = 1'b0;
      if (accept && match) begin
         priority if (req_report_id == REPORT_PAN) begin
            if (!req_foreground) begin
               axes_in = '0;
            end else begin
               axes_in[0] = req_word_a;
               axes_in[1] = req_word_b;
               axes_in[2] = req_word_c;
               if (req_report_size >= LONG_REPORT_MIN) begin
                  axes_in[3] = req_word_d;
                  axes_in[4] = req_word_e;
                  axes_in[5] = req_word_f;
                  push       = 1'b1;
               end
            end
         end else if (req_report_id == REPORT_ROT) begin
            if (req_foreground) begin
               axes_in[3] = req_word_a;
               axes_in[4] = req_word_b;
               axes_in[5] = req_word_c;
               push       = 1'b1;
            end
         end else if (req_report_id == REPORT_KEYS) begin
            prev_keys_in = keys;
            push         = req_foreground && (emit_mask != '0);
         end else begin
            push = 1'b0;
         end
      end
   end

   always_comb begin
      push_data.is_key = (req_report_id == REPORT_KEYS);
      push_data.axes   = axes_in;
      push_data.keys   = keys;
      push_data.mask   = emit_mask;
      push_data.pid    = req_product_id;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vendor_ff    <= VENDOR_RESET;
         axes_ff      <= '0;
         prev_keys_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            vendor_ff <= csr_wdata;
         end
         axes_ff      <= axes_in;
         prev_keys_ff <= prev_keys_in;
      end
   end

   `ASSERT_HOLDS(a_key_push_nonempty, clock, reset,
                 (push && push_data.is_key) |-> (push_data.mask != '0))
   `ASSERT_NEVER(a_push_needs_accept, clock, reset, push && !accept)

endmodule

// ===== rtl/hidd_back.sv =====
`include "assert_macros.svh"

module hidd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 empty,
   input  hidd_pkg::cmd_type    head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_kind,
   output logic [5:0]           rsp_key_code,
   output hidd_pkg::axes_type   rsp_axes,
   output logic                 rsp_last
);
   import hidd_pkg::*;

   logic                  busy_ff, busy_in;
   logic [KEY_COUNT-1:0]  remain_ff, remain_in;
   logic [KEY_COUNT-1:0]  keys_ff, keys_in;
   logic [15:0]           pid_ff, pid_in;
   logic                  out_valid_ff, out_valid_in;
   logic [1:0]            out_kind_ff, out_kind_in;
   logic [5:0]            out_code_ff, out_code_in;
   axes_type              out_axes_ff, out_axes_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_free;
   logic [KEY_COUNT-1:0]  lowest;
   logic [KEY_W-1:0]      key_idx;
   logic                  scan_last;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign lowest    = remain_ff & (~remain_ff + 1'b1);
   assign scan_last = ((remain_ff & ~lowest) == '0);

   always_comb begin
      key_idx = '0;
      for (int i = 0; i < KEY_COUNT; i++) begin
         if (lowest[i]) begin
            key_idx = key_idx | KEY_W'(i);
         end
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      remain_in    = remain_ff;
      keys_in      = keys_ff;
      pid_in       = pid_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_kind_in  = out_kind_ff;
      out_code_in  = out_code_ff;
      out_axes_in  = out_axes_ff;
      out_last_in  = out_last_ff;
      pop          = 1'b0;
      if (busy_ff) begin
         if (out_free) begin
            out_valid_in = 1'b1;
            out_kind_in  = keys_ff[key_idx] ? KIND_KEY_DOWN : KIND_KEY_UP;
            out_code_in  = map_key(pid_ff, KEY_CODE_W'(key_idx) + 1'b1);
            out_axes_in  = '0;
            out_last_in  = scan_last;
            remain_in    = remain_ff & ~lowest;
            busy_in      = !scan_last;
         end
      end else if (!empty) begin
         if (head.is_key) begin
            pop       = 1'b1;
            busy_in   = 1'b1;
            remain_in = head.mask;
            keys_in   = head.keys;
            pid_in    = head.pid;
         end else if (out_free) begin
            pop          = 1'b1;
            out_valid_in = 1'b1;
            out_kind_in  = KIND_MOTION;
            out_code_in  = '0;
            out_axes_in  = head.axes;
            out_last_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff   <= remain_in;
      keys_ff     <= keys_in;
      pid_ff      <= pid_in;
      out_kind_ff <= out_kind_in;
      out_code_ff <= out_code_in;
      out_axes_ff <= out_axes_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_kind     = out_kind_ff;
   assign rsp_key_code = out_code_ff;
   assign rsp_axes     = out_axes_ff;
   assign rsp_last     = out_last_ff;

   `ASSERT_HOLDS(a_busy_has_keys, clock, reset, busy_ff |-> (remain_ff != '0))
   `ASSERT_HOLDS(a_motion_is_last, clock, reset,
                 (out_valid_ff && (out_kind_ff == KIND_MOTION)) |->
                 (out_last_ff && (out_code_ff == '0)))

endmodule

// ===== rtl/multi_axis_hid_report_decoder.sv =====
// channel   direction  handshake              payload
// csr       in         csr_valid/csr_ready    csr_wdata (accepted vendor id)
// req       in         req_valid/req_ready    one HID report word
// rsp       out        rsp_valid/rsp_ready    one motion or key event word
//
// A report is taken whenever the queue has room; the front updates the axis cache and key
// state at once and, when a word is due, queues a command in a two-entry queue.
// The back end moves a motion word from the queue head into the output register; a key
// report is loaded into the scan, which emits its key events (up to 32) lowest key first.
// Synchronous reset clears the cache, key state, queue and output register.
// req_ready drops only while the queue is full; rsp stalls hold the word.
module multi_axis_hid_report_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_is_hid,
   input  logic               req_foreground,
   input  logic [15:0]        req_vendor_id,
   input  logic [15:0]        req_product_id,
   input  logic [7:0]         req_report_size,
   input  logic [7:0]         req_report_id,
   input  logic [15:0]        req_word_a,
   input  logic [15:0]        req_word_b,
   input  logic [15:0]        req_word_c,
   input  logic [15:0]        req_word_d,
   input  logic [15:0]        req_word_e,
   input  logic [15:0]        req_word_f,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic [5:0]         rsp_key_code,
   output logic signed [15:0] rsp_pan_x,
   output logic signed [15:0] rsp_pan_y,
   output logic signed [15:0] rsp_pan_z,
   output logic signed [15:0] rsp_rot_x,
   output logic signed [15:0] rsp_rot_y,
   output logic signed [15:0] rsp_rot_z,
   output logic               rsp_last
);
   import hidd_pkg::*;

   logic     push;
   cmd_type  push_data;
   logic     full;
   logic     pop;
   cmd_type  head;
   logic     empty;
   axes_type rsp_axes;

   hidd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_is_hid      (req_is_hid),
      .req_foreground  (req_foreground),
      .req_vendor_id   (req_vendor_id),
      .req_product_id  (req_product_id),
      .req_report_size (req_report_size),
      .req_report_id   (req_report_id),
      .req_word_a      (req_word_a),
      .req_word_b      (req_word_b),
      .req_word_c      (req_word_c),
      .req_word_d      (req_word_d),
      .req_word_e      (req_word_e),
      .req_word_f      (req_word_f),
      .push            (push),
      .push_data       (push_data),
      .full            (full)
   );

   hidd_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (head),
      .empty     (empty)
   );

   hidd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .empty        (empty),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_key_code (rsp_key_code),
      .rsp_axes     (rsp_axes),
      .rsp_last     (rsp_last)
   );

   assign rsp_pan_x = $signed(rsp_axes[0]);
   assign rsp_pan_y = $signed(rsp_axes[1]);
   assign rsp_pan_z = $signed(rsp_axes[2]);
   assign rsp_rot_x = $signed(rsp_axes[3]);
   assign rsp_rot_y = $signed(rsp_axes[4]);
   assign rsp_rot_z = $signed(rsp_axes[5]);

endmodule

// ===== bench/tb_multi_axis_hid_report_decoder.sv =====
module tb_multi_axis_hid_report_decoder;
   import hidd_pkg::*;

   localparam int SETTLE_CYCLES = 120;
   localparam int HOLD_CYCLES   = 200;
   localparam int STUCK_LIMIT   = 2000;

   localparam logic [5:0] CODES_A [21] = '{
      6'd0, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd3, 6'd4, 6'd5, 6'd6,
      6'd23, 6'd24, 6'd25, 6'd26, 6'd2, 6'd1, 6'd30, 6'd31, 6'd29, 6'd27
   };
   localparam logic [5:0] CODES_B [16] = '{
      6'd0, 6'd13, 6'd14, 6'd3, 6'd4, 6'd5, 6'd6, 6'd23,
      6'd24, 6'd25, 6'd26, 6'd2, 6'd1, 6'd30, 6'd31, 6'd27
   };

   typedef struct packed {
      logic             is_hid;
      logic             fg;
      logic [15:0]      vendor;
      logic [15:0]      product;
      logic [7:0]       size;
      logic [7:0]       rid;
      logic [5:0][15:0] words;
   } hid_report_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [5:0]       code;
      logic [5:0][15:0] axes;
      logic             last;
   } hid_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_wdata = '0;

   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic        req_is_hid      = 1'b0;
   logic        req_foreground  = 1'b0;
   logic [15:0] req_vendor_id   = '0;
   logic [15:0] req_product_id  = '0;
   logic [7:0]  req_report_size = '0;
   logic [7:0]  req_report_id   = '0;
   logic [15:0] req_word_a      = '0;
   logic [15:0] req_word_b      = '0;
   logic [15:0] req_word_c      = '0;
   logic [15:0] req_word_d      = '0;
   logic [15:0] req_word_e      = '0;
   logic [15:0] req_word_f      = '0;

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_kind;
   logic [5:0]         rsp_key_code;
   logic signed [15:0] rsp_pan_x;
   logic signed [15:0] rsp_pan_y;
   logic signed [15:0] rsp_pan_z;
   logic signed [15:0] rsp_rot_x;
   logic signed [15:0] rsp_rot_y;
   logic signed [15:0] rsp_rot_z;
   logic               rsp_last;

   // predictor state
   logic [15:0]      vendor_sel = VENDOR_RESET;
   logic [5:0][15:0] axis_copy  = '0;
   logic [31:0]      key_copy   = '0;
   hid_event_type    events_due[$];

   int error_count     = 0;
   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   int stuck_cycles    = 0;
   bit rsp_hold_request = 1'b0;

   multi_axis_hid_report_decoder i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_is_hid      (req_is_hid),
      .req_foreground  (req_foreground),
      .req_vendor_id   (req_vendor_id),
      .req_product_id  (req_product_id),
      .req_report_size (req_report_size),
      .req_report_id   (req_report_id),
      .req_word_a      (req_word_a),
      .req_word_b      (req_word_b),
      .req_word_c      (req_word_c),
      .req_word_d      (req_word_d),
      .req_word_e      (req_word_e),
      .req_word_f      (req_word_f),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_key_code    (rsp_key_code),
      .rsp_pan_x       (rsp_pan_x),
      .rsp_pan_y       (rsp_pan_y),
      .rsp_pan_z       (rsp_pan_z),
      .rsp_rot_x       (rsp_rot_x),
      .rsp_rot_y       (rsp_rot_y),
      .rsp_rot_z       (rsp_rot_z),
      .rsp_last        (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [5:0] lookup_code(input logic [15:0] pid, input int key);
      if (pid == PROD_A) begin
         if (key < 21) return CODES_A[5'(key)];
         return 6'd0;
      end
      if (pid == PROD_B) begin
         if (key < 16) return CODES_B[4'(key)];
         return 6'd0;
      end
      return 6'(key);
   endfunction

   function automatic hid_event_type motion_event();
      hid_event_type ev;
      ev.kind = KIND_MOTION;
      ev.code = '0;
      ev.axes = axis_copy;
      ev.last = 1'b0;
      return ev;
   endfunction

   // updates the cache and key state and queues the words this report causes
   function automatic void decode_report(input hid_report_type r);
      hid_event_type batch[$];
      hid_event_type ev;
      logic [31:0]   keys;
      logic [31:0]   change;
      logic [5:0]    code;
      if (!r.is_hid || r.vendor != vendor_sel) return;
      if (r.rid == REPORT_PAN) begin
         if (!r.fg) begin
            axis_copy = '0;
         end else begin
            axis_copy[2:0] = r.words[2:0];
            if (r.size >= LONG_REPORT_MIN) begin
               axis_copy[5:3] = r.words[5:3];
               batch.push_back(motion_event());
            end
         end
      end else if (r.rid == REPORT_ROT) begin
         if (r.fg) begin
            axis_copy[5:3] = r.words[2:0];
            batch.push_back(motion_event());
         end
      end else if (r.rid == REPORT_KEYS) begin
         keys     = {r.words[1], r.words[0]};
         change   = keys ^ key_copy;
         key_copy = keys;
         if (r.fg) begin
            for (int k = 1; k <= KEY_COUNT; k++) begin
               if (change[k-1]) begin
                  code = lookup_code(r.product, k);
                  if (code != 6'd0) begin
                     ev.kind = keys[k-1] ? KIND_KEY_DOWN : KIND_KEY_UP;
                     ev.code = code;
                     ev.axes = '0;
                     ev.last = 1'b0;
                     batch.push_back(ev);
                  end
               end
            end
         end
      end
      foreach (batch[i]) begin
         ev      = batch[i];
         ev.last = (i == batch.size() - 1);
         events_due.push_back(ev);
      end
   endfunction

   function automatic hid_report_type report_of(input logic hid, input logic fg,
                                                input logic [15:0] vendor,
                                                input logic [15:0] pid,
                                                input logic [7:0] size,
                                                input logic [7:0] rid,
                                                input logic [95:0] words);
      hid_report_type r;
      r.is_hid  = hid;
      r.fg      = fg;
      r.vendor  = vendor;
      r.product = pid;
      r.size    = size;
      r.rid     = rid;
      r.words   = words;
      return r;
   endfunction

   function automatic hid_report_type random_report();
      hid_report_type r;
      r.words = {$urandom, $urandom, $urandom};
      case ($urandom_range(3))
         0:       r.product = PROD_A;
         1:       r.product = PROD_B;
         default: r.product = 16'($urandom);
      endcase
      if ($urandom_range(99) < 85) begin
         r.is_hid = 1'b1;
         r.vendor = vendor_sel;
         r.fg     = ($urandom_range(9) != 0);
         r.rid    = 8'($urandom_range(3, 1));
         r.size   = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(14, 11));
         // sparse key changes give short event bursts
         if (r.rid == REPORT_KEYS && $urandom_range(1) == 1)
            {r.words[1], r.words[0]} = key_copy ^ ($urandom & $urandom & $urandom);
      end else begin
         r.is_hid = 1'($urandom);
         r.fg     = 1'($urandom);
         r.vendor = ($urandom_range(1) == 1) ? vendor_sel : 16'($urandom);
         r.rid    = 8'($urandom);
         r.size   = 8'($urandom);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h, want %0h", what, got, want);
      error_count++;
   endtask

   task automatic check_event();
      hid_event_type got;
      hid_event_type want;
      got.kind    = rsp_kind;
      got.code    = rsp_key_code;
      got.axes[0] = rsp_pan_x;
      got.axes[1] = rsp_pan_y;
      got.axes[2] = rsp_pan_z;
      got.axes[3] = rsp_rot_x;
      got.axes[4] = rsp_rot_y;
      got.axes[5] = rsp_rot_z;
      got.last    = rsp_last;
      if (events_due.size() == 0) begin
         report_mismatch("word with nothing due", 32'(got.kind), 32'd0);
         return;
      end
      want = events_due.pop_front();
      if (got.kind != want.kind)
         report_mismatch("kind", 32'(got.kind), 32'(want.kind));
      if (got.code != want.code)
         report_mismatch("key_code", 32'(got.code), 32'(want.code));
      if (got.axes[0] != want.axes[0])
         report_mismatch("pan_x", 32'(got.axes[0]), 32'(want.axes[0]));
      if (got.axes[1] != want.axes[1])
         report_mismatch("pan_y", 32'(got.axes[1]), 32'(want.axes[1]));
      if (got.axes[2] != want.axes[2])
         report_mismatch("pan_z", 32'(got.axes[2]), 32'(want.axes[2]));
      if (got.axes[3] != want.axes[3])
         report_mismatch("rot_x", 32'(got.axes[3]), 32'(want.axes[3]));
      if (got.axes[4] != want.axes[4])
         report_mismatch("rot_y", 32'(got.axes[4]), 32'(want.axes[4]));
      if (got.axes[5] != want.axes[5])
         report_mismatch("rot_z", 32'(got.axes[5]), 32'(want.axes[5]));
      if (got.last != want.last)
         report_mismatch("last", 32'(got.last), 32'(want.last));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_event();
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver: random stalls, or one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_hold_request = 1'b0;
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_report(input hid_report_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_is_hid      <= r.is_hid;
      req_foreground  <= r.fg;
      req_vendor_id   <= r.vendor;
      req_product_id  <= r.product;
      req_report_size <= r.size;
      req_report_id   <= r.rid;
      req_word_a      <= r.words[0];
      req_word_b      <= r.words[1];
      req_word_c      <= r.words[2];
      req_word_d      <= r.words[3];
      req_word_e      <= r.words[4];
      req_word_f      <= r.words[5];
      do @(posedge clock); while (!req_ready);
      decode_report(r);
   endtask

   // settle covers key scans that emit nothing
   task automatic wait_all_events(input int settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (events_due.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_vendor(input logic [15:0] vendor);
      wait_all_events(SETTLE_CYCLES);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= vendor;
      do @(posedge clock); while (!csr_ready);
      vendor_sel = vendor;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_motion_reports();
      send_report(report_of(1, 1, vendor_sel, 16'h0000, 8'd13, REPORT_PAN,
         {16'h8001, 16'h0001, 16'h0000, 16'hffff, 16'h8000, 16'h7fff}));
      // short report: pan cached, nothing sent
      send_report(report_of(1, 1, vendor_sel, 16'h0000, 8'd12, REPORT_PAN,
         {16'h1111, 16'h2222, 16'h3333, 16'h0123, 16'h4567, 16'h89ab}));
      send_report(report_of(1, 1, vendor_sel, 16'h0000, 8'd0, REPORT_ROT,
         {48'h0, 16'hfedc, 16'hba98, 16'h7654}));
      send_report(report_of(1, 1, vendor_sel, 16'hffff, 8'd255, REPORT_PAN, {96{1'b1}}));
      // background pan report clears every axis
      send_report(report_of(1, 0, vendor_sel, 16'h0000, 8'd13, REPORT_PAN, {96{1'b1}}));
      send_report(report_of(1, 1, vendor_sel, 16'hffff, 8'd255, REPORT_ROT,
         {48'h0, 16'h8000, 16'h7fff, 16'h0001}));
      send_report(report_of(1, 0, vendor_sel, 16'h0000, 8'd13, REPORT_ROT, {96{1'b1}}));
      send_report(report_of(1, 1, vendor_sel, 16'h0000, 8'd0, REPORT_PAN,
         {48'h0, 16'h5555, 16'haaaa, 16'h00ff}));
   endtask

   task automatic test_key_reports();
      send_report(report_of(1, 1, vendor_sel, 16'h0000, 8'd5, REPORT_KEYS,
         {64'h0, 32'hffff_ffff}));
      send_report(report_of(1, 1, vendor_sel, 16'h0000, 8'd5, REPORT_KEYS, {64'h0, 32'h0}));
      // keys past the table end map to nothing
      send_report(report_of(1, 1, vendor_sel, PROD_A, 8'd5, REPORT_KEYS,
         {64'h0, 32'hffff_ffff}));
      send_report(report_of(1, 1, vendor_sel, PROD_B, 8'd5, REPORT_KEYS,
         {64'h0, 32'h0000_5555}));
      send_report(report_of(1, 0, vendor_sel, PROD_A, 8'd5, REPORT_KEYS,
         {64'h0, 32'h1234_abcd}));
      send_report(report_of(1, 1, vendor_sel, 16'hffff, 8'd5, REPORT_KEYS,
         {64'h0, 32'h1234_abcd}));
      send_report(report_of(1, 1, vendor_sel, 16'hffff, 8'd5, REPORT_KEYS,
         {64'h0, 32'hedcb_5432}));
      send_report(report_of(1, 1, vendor_sel, PROD_A, 8'd5, REPORT_KEYS, {64'h0, 32'h0}));
   endtask

   task automatic test_ignored_reports();
      send_report(report_of(0, 1, vendor_sel, 16'h0000, 8'd13, REPORT_ROT, {96{1'b1}}));
      send_report(report_of(1, 1, vendor_sel ^ 16'h0001, 16'h0000, 8'd13, REPORT_ROT,
         {96{1'b1}}));
      send_report(report_of(1, 1, vendor_sel, 16'h0000, 8'd13, 8'd0, {96{1'b1}}));
      send_report(report_of(1, 1, vendor_sel, 16'h0000, 8'd13, 8'd4, {96{1'b1}}));
      send_report(report_of(1, 1, vendor_sel, 16'h0000, 8'd13, 8'hff, {96{1'b1}}));
   endtask

   task automatic test_vendor_register();
      logic [15:0] ids [4];
      ids = '{16'h0000, 16'hffff, 16'($urandom), VENDOR_RESET};
      foreach (ids[i]) begin
         write_vendor(ids[i]);
         send_report(report_of(1, 1, ids[i], 16'h0000, 8'd13, REPORT_PAN,
            {$urandom, $urandom, $urandom}));
         send_report(report_of(1, 1, ~ids[i], 16'h0000, 8'd13, REPORT_ROT,
            {$urandom, $urandom, $urandom}));
         send_report(report_of(1, 1, ids[i], 16'h0000, 8'd2, REPORT_KEYS,
            {$urandom, $urandom, $urandom}));
      end
   endtask

   task automatic test_random_traffic(input int count, input int send_pct,
                                      input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         send_report(random_report());
         if ($urandom_range(39) == 0) wait_all_events(0);
      end
   endtask

   // long output stall while reports keep coming, so the input backs up
   task automatic test_output_stall();
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      rsp_hold_request = 1'b1;
      for (int i = 0; i < 8; i++)
         send_report(report_of(1, 1, vendor_sel, 16'h0000, 8'd5, REPORT_KEYS,
            {64'h0, ~key_copy}));
      wait_all_events(0);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_motion_reports();
      test_key_reports();
      test_ignored_reports();
      test_vendor_register();
      test_random_traffic(40, 35, 76);
      test_random_traffic(40, 76, 35);
      test_random_traffic(40, 0, 0);
      test_output_stall();

      wait_all_events(SETTLE_CYCLES);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
